// ===== design/iptc_pkg.sv =====
// Shared types and constants for the IPTC record stream parser.
package iptc_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] MARKER_BYTE = 8'h1c;
  localparam logic [7:0] REC_ONE     = 8'h01;
  localparam logic [7:0] REC_TWO     = 8'h02;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_NUM1,
    PH_NUM2,
    PH_SHORTLEN,
    PH_LONGLEN,
    PH_DATA,
    PH_MARKER,
    PH_DONE
  } iptc_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
  } iptc_in_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  first_number;
    logic [7:0]  second_number;
    logic [15:0] record_length;
    logic [7:0]  payload_byte;
    logic        last_of_record;
    logic        found_any;
  } iptc_out_t;

  typedef struct packed {
    logic [1:0] cnt;
    iptc_out_t  r0;
    iptc_out_t  r1;
  } iptc_push_t;

endpackage

// ===== design/iptc_parse_core.sv =====
// Input stage register and per-byte parse logic producing up to two results.
module iptc_parse_core #(
  parameter logic [31:0] MAX_BLOCK = 32'd65535
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  iptc_pkg::iptc_in_t  in_data,
  input  logic [15:0]         block_length,
  input  logic                room,
  output iptc_pkg::iptc_push_t push
);

  logic                   stg_v_r;
  iptc_pkg::iptc_in_t     stg_r;
  logic                   do_proc;

  iptc_pkg::iptc_phase_t  ph_r, ph_nxt;
  logic [15:0]            pos_r, pos_nxt;
  logic                   pm_r, pm_nxt;
  logic [2:0]             hc_r, hc_nxt;
  logic [7:0]             hf_r, hf_nxt;
  logic [7:0]             hs_r, hs_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic [15:0]            rem_r, rem_nxt;
  logic                   af_r, af_nxt;

  logic [15:0]            total;
  logic [15:0]            bl_eff;
  logic [7:0]             b;
  logic                   fin;
  logic                   over;
  iptc_pkg::iptc_out_t    res [2];
  logic [1:0]             n;

  assign do_proc  = stg_v_r && room;
  assign in_ready = !stg_v_r || room;
  assign b        = stg_r.data_byte;

  always_comb begin
    bl_eff = ({16'd0, block_length} > MAX_BLOCK) ? MAX_BLOCK[15:0] : block_length;
    total  = (bl_eff == 16'd0) ? 16'd1 : bl_eff;
  end

  always_comb begin
    ph_nxt  = ph_r;
    pos_nxt = pos_r;
    pm_nxt  = pm_r;
    hc_nxt  = hc_r;
    hf_nxt  = hf_r;
    hs_nxt  = hs_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    af_nxt  = af_r;
    res[0]  = '0;
    res[1]  = '0;
    n       = 2'd0;
    fin     = 1'b0;
    over    = 1'b0;
    if (do_proc) begin
      if (stg_r.block_start) begin
        ph_nxt  = iptc_pkg::PH_SEARCH;
        pos_nxt = '0;
        pm_nxt  = 1'b0;
        hc_nxt  = '0;
        hf_nxt  = '0;
        hs_nxt  = '0;
        acc_nxt = '0;
        rem_nxt = '0;
        af_nxt  = 1'b0;
      end
      if (pos_nxt < total) begin
        case (ph_nxt)
          iptc_pkg::PH_SEARCH: begin
            if (pm_nxt && (b == iptc_pkg::REC_ONE || b == iptc_pkg::REC_TWO)) begin
              if ({1'b0, pos_nxt} + 17'd4 >= {1'b0, total}) begin
                ph_nxt = iptc_pkg::PH_DONE;
              end else begin
                hf_nxt = b;
                ph_nxt = iptc_pkg::PH_NUM2;
              end
            end
            pm_nxt = (b == iptc_pkg::MARKER_BYTE);
          end
          iptc_pkg::PH_MARKER: begin
            if (b != iptc_pkg::MARKER_BYTE || {1'b0, pos_nxt} + 17'd5 >= {1'b0, total}) begin
              ph_nxt = iptc_pkg::PH_DONE;
            end else begin
              ph_nxt = iptc_pkg::PH_NUM1;
            end
          end
          iptc_pkg::PH_NUM1: begin
            hf_nxt = b;
            ph_nxt = iptc_pkg::PH_NUM2;
          end
          iptc_pkg::PH_NUM2: begin
            hs_nxt = b;
            hc_nxt = '0;
            ph_nxt = iptc_pkg::PH_SHORTLEN;
          end
          iptc_pkg::PH_SHORTLEN: begin
            if (hc_nxt == 3'd0) begin
              if (b[7]) begin
                if ({1'b0, pos_nxt} + 17'd6 >= {1'b0, total}) begin
                  ph_nxt = iptc_pkg::PH_DONE;
                end else begin
                  hc_nxt  = '0;
                  acc_nxt = '0;
                  ph_nxt  = iptc_pkg::PH_LONGLEN;
                end
              end else begin
                acc_nxt = {24'd0, b};
                hc_nxt  = 3'd1;
              end
            end else begin
              acc_nxt = {16'd0, acc_nxt[7:0], b};
              fin     = 1'b1;
            end
          end
          iptc_pkg::PH_LONGLEN: begin
            if (hc_nxt != 3'd0) begin
              acc_nxt = {acc_nxt[23:0], b};
            end
            if (hc_nxt >= 3'd4) begin
              fin = 1'b1;
            end else begin
              hc_nxt = hc_nxt + 3'd1;
            end
          end
          iptc_pkg::PH_DATA: begin
            rem_nxt = rem_nxt - 16'd1;
            res[n[0]].item_kind      = iptc_pkg::KIND_DATA;
            res[n[0]].payload_byte   = b;
            res[n[0]].last_of_record = (rem_nxt == 16'd0);
            n = n + 2'd1;
            if (rem_nxt == 16'd0) begin
              ph_nxt = iptc_pkg::PH_MARKER;
            end
          end
          default: begin
            ph_nxt = iptc_pkg::PH_DONE;
          end
        endcase
        if (fin) begin
          over = (acc_nxt[31:16] != 16'd0) ||
                 ({2'b0, pos_nxt} + 18'd1 + {2'b0, acc_nxt[15:0]} > {2'b0, total});
          if (over) begin
            ph_nxt = iptc_pkg::PH_DONE;
          end else begin
            res[n[0]].item_kind     = iptc_pkg::KIND_HEADER;
            res[n[0]].first_number  = hf_nxt;
            res[n[0]].second_number = hs_nxt;
            res[n[0]].record_length = acc_nxt[15:0];
            n       = n + 2'd1;
            af_nxt  = 1'b1;
            rem_nxt = acc_nxt[15:0];
            ph_nxt  = (acc_nxt[15:0] == 16'd0) ? iptc_pkg::PH_MARKER : iptc_pkg::PH_DATA;
          end
        end
        if (pos_nxt == total - 16'd1) begin
          res[n[0]].item_kind = iptc_pkg::KIND_END;
          res[n[0]].found_any = af_nxt;
          n = n + 2'd1;
        end
        pos_nxt = pos_nxt + 16'd1;
      end
    end
  end

  assign push.cnt = n;
  assign push.r0  = res[0];
  assign push.r1  = res[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      ph_r    <= iptc_pkg::PH_SEARCH;
      pos_r   <= '0;
      pm_r    <= 1'b0;
      hc_r    <= '0;
      hf_r    <= '0;
      hs_r    <= '0;
      acc_r   <= '0;
      rem_r   <= '0;
      af_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        stg_v_r <= in_valid;
      end
      ph_r  <= ph_nxt;
      pos_r <= pos_nxt;
      pm_r  <= pm_nxt;
      hc_r  <= hc_nxt;
      hf_r  <= hf_nxt;
      hs_r  <= hs_nxt;
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      af_r  <= af_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_r <= in_data;
    end
  end

endmodule

// ===== design/iptc_out_fifo.sv =====
// Result queue taking up to two results per cycle and delivering one.
module iptc_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iptc_pkg::iptc_push_t push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output iptc_pkg::iptc_out_t  out_data
);

  localparam int unsigned AW = iptc_pkg::FIFO_AW;

  iptc_pkg::iptc_out_t mem [iptc_pkg::FIFO_DEPTH];
  logic [AW-1:0]       wp_r, wp_nxt;
  logic [AW-1:0]       rp_r, rp_nxt;
  logic [AW:0]         count_r, count_nxt;
  logic                pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rp_r];
  assign room      = (count_r <= (AW+1)'(iptc_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wp_nxt    = wp_r + AW'(push.cnt);
    rp_nxt    = rp_r + AW'(pop);
    count_nxt = count_r + (AW+1)'(push.cnt) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wp_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wp_r + AW'(1)] <= push.r1;
    end
  end

endmodule

// ===== design/iptc_record_stream_parser.sv =====
// Top level of the IPTC record stream parser.
// Takes one IPTC block byte per transaction, with the block's byte count
// set beforehand on the cfg port, and emits record headers, record data
// bytes and one end-of-block item. A byte is accepted every cycle while
// the result queue has room for two results; each byte passes one input
// stage register and its results land in a four-entry queue that drives
// out_valid; a byte waits in the stage register while the queue lacks
// room. Bytes that give two results (header plus end, data plus end) are
// drained at one result per cycle from the queue while out_ready is high.
module iptc_record_stream_parser #(
  parameter logic [31:0] MAX_BLOCK = 32'd65535
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  iptc_pkg::iptc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output iptc_pkg::iptc_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_block_length
);

  logic [15:0]          block_length_r;
  logic                 room;
  iptc_pkg::iptc_push_t push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_length_r <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      block_length_r <= cfg_block_length;
    end
  end

  iptc_parse_core #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .block_length(block_length_r),
    .room        (room),
    .push        (push)
  );

  iptc_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== dv/iptc_record_stream_parser_tb.sv =====
// Testbench for iptc_record_stream_parser: random and directed byte streams, predicted items.
`timescale 1ns / 100ps

module iptc_record_stream_parser_tb;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 4;
  localparam int PHASE_ITEMS = 58;

  class record_item_tracker;
    logic [15:0]           blk_len;
    iptc_pkg::iptc_phase_t stage;
    logic [15:0]           pos;
    bit                    saw_marker;
    logic [2:0]            hdr_bytes;
    logic [7:0]            rec_no;
    logic [7:0]            set_no;
    logic [31:0]           len_acc;
    logic [15:0]           bytes_left;
    bit                    any_record;
    iptc_pkg::iptc_out_t   awaited_items[$];
    int                    fails;

    function new();
      blk_len = 16'd1;
      fails = 0;
      restart();
    endfunction

    function void restart();
      stage = iptc_pkg::PH_SEARCH;
      pos = '0;
      saw_marker = 1'b0;
      hdr_bytes = '0;
      rec_no = '0;
      set_no = '0;
      len_acc = '0;
      bytes_left = '0;
      any_record = 1'b0;
    endfunction

    function void set_length(logic [15:0] v);
      blk_len = v;
    endfunction

    function void flag(string msg);
      fails++;
      if (fails <= 10) $display("%s", msg);
    endfunction

    function string show(iptc_pkg::iptc_out_t r);
      return $sformatf("kind=%0d num=%02h/%02h len=%0d byte=%02h last=%0b found=%0b",
                       r.item_kind, r.first_number, r.second_number, r.record_length,
                       r.payload_byte, r.last_of_record, r.found_any);
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] f1, logic [7:0] f2, logic [15:0] len,
                       logic [7:0] pay, bit last, bit found);
      iptc_pkg::iptc_out_t r;
      r.item_kind      = kind;
      r.first_number   = f1;
      r.second_number  = f2;
      r.record_length  = len;
      r.payload_byte   = pay;
      r.last_of_record = last;
      r.found_any      = found;
      awaited_items.push_back(r);
    endfunction

    // length complete at position p, data would start at p + 1
    function void close_header(longint unsigned p, longint unsigned total);
      longint unsigned len;
      len = len_acc;
      if (len > total || p + 1 + len > total) begin
        stage = iptc_pkg::PH_DONE;
      end else begin
        emit(iptc_pkg::KIND_HEADER, rec_no, set_no, len_acc[15:0], 8'h00, 1'b0, 1'b0);
        any_record = 1'b1;
        bytes_left = len_acc[15:0];
        if (len == 0) stage = iptc_pkg::PH_MARKER;
        else stage = iptc_pkg::PH_DATA;
      end
    endfunction

    // returns 1 when the byte falls inside the current block
    function bit parse_byte(iptc_pkg::iptc_in_t item);
      logic [7:0] b;
      longint unsigned total;
      longint unsigned p;
      b = item.data_byte;
      if (item.block_start) restart();
      total = (blk_len == 16'd0) ? 1 : blk_len;
      p = pos;
      if (p >= total) return 1'b0;
      case (stage)
        iptc_pkg::PH_SEARCH: begin
          if (saw_marker && (b == iptc_pkg::REC_ONE || b == iptc_pkg::REC_TWO)) begin
            if (p + 4 >= total) begin
              stage = iptc_pkg::PH_DONE;
            end else begin
              rec_no = b;
              stage = iptc_pkg::PH_NUM2;
            end
          end
          saw_marker = (b == iptc_pkg::MARKER_BYTE);
        end
        iptc_pkg::PH_MARKER: begin
          if (b != iptc_pkg::MARKER_BYTE || p + 5 >= total) stage = iptc_pkg::PH_DONE;
          else stage = iptc_pkg::PH_NUM1;
        end
        iptc_pkg::PH_NUM1: begin
          rec_no = b;
          stage = iptc_pkg::PH_NUM2;
        end
        iptc_pkg::PH_NUM2: begin
          set_no = b;
          hdr_bytes = '0;
          stage = iptc_pkg::PH_SHORTLEN;
        end
        iptc_pkg::PH_SHORTLEN: begin
          if (hdr_bytes == 0) begin
            if (b[7]) begin
              if (p + 6 >= total) begin
                stage = iptc_pkg::PH_DONE;
              end else begin
                hdr_bytes = '0;
                len_acc = '0;
                stage = iptc_pkg::PH_LONGLEN;
              end
            end else begin
              len_acc = {24'h0, b};
              hdr_bytes = 3'd1;
            end
          end else begin
            len_acc = {16'h0, len_acc[7:0], b};
            close_header(p, total);
          end
        end
        iptc_pkg::PH_LONGLEN: begin
          // first byte here is the second skipped byte
          if (hdr_bytes != 0) len_acc = {len_acc[23:0], b};
          if (hdr_bytes >= 4) close_header(p, total);
          else hdr_bytes = hdr_bytes + 3'd1;
        end
        iptc_pkg::PH_DATA: begin
          bytes_left = bytes_left - 16'd1;
          emit(iptc_pkg::KIND_DATA, 8'h00, 8'h00, 16'h0, b, bytes_left == 0, 1'b0);
          if (bytes_left == 0) stage = iptc_pkg::PH_MARKER;
        end
        default: stage = iptc_pkg::PH_DONE;
      endcase
      if (p == total - 1)
        emit(iptc_pkg::KIND_END, 8'h00, 8'h00, 16'h0, 8'h00, 1'b0, any_record);
      pos = pos + 16'd1;
      return 1'b1;
    endfunction

    function void match_item(iptc_pkg::iptc_out_t got);
      iptc_pkg::iptc_out_t want;
      string diffs;
      if (awaited_items.size() == 0) begin
        flag($sformatf("unexpected result: %s", show(got)));
        return;
      end
      want = awaited_items.pop_front();
      diffs = "";
      if (got.item_kind !== want.item_kind) diffs = {diffs, " item_kind"};
      if (got.first_number !== want.first_number) diffs = {diffs, " first_number"};
      if (got.second_number !== want.second_number) diffs = {diffs, " second_number"};
      if (got.record_length !== want.record_length) diffs = {diffs, " record_length"};
      if (got.payload_byte !== want.payload_byte) diffs = {diffs, " payload_byte"};
      if (got.last_of_record !== want.last_of_record) diffs = {diffs, " last_of_record"};
      if (got.found_any !== want.found_any) diffs = {diffs, " found_any"};
      if (diffs != "")
        flag($sformatf("mismatch in%s: expected %s, actual %s", diffs, show(want), show(got)));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  iptc_pkg::iptc_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  iptc_pkg::iptc_out_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [15:0]         cfg_block_length = '0;

  record_item_tracker book;
  int in_gap_max = 0;
  int out_gap_max = 0;
  bit hold_req = 1'b0;
  int live_items = 0;

  always #5 clk = ~clk;

  iptc_record_stream_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_block_length (cfg_block_length)
  );

  task automatic send_byte(logic [7:0] b, bit start);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, block_start: start};
    do @(posedge clk); while (!in_ready);
    live_items += book.parse_byte(in_data);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_length(logic [15:0] v);
    idle_input();
    while (book.awaited_items.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_block_length <= v;
    do @(posedge clk); while (!cfg_ready);
    book.set_length(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_block(logic [7:0] q[$], bit noisy);
    for (int i = 0; i < q.size(); i++)
      send_byte(q[i], i == 0 || (noisy && $urandom_range(0, 7) == 0));
  endtask

  // records sized to fit in 'fit' bytes, then 'extra' bytes past the block
  function automatic void build_block(int fit, int extra, ref logic [7:0] q[$]);
    int room;
    int hdr;
    int n;
    logic [31:0] len;
    bit wide;
    bit lead_rec;
    q.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat (fit + extra) q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
    lead_rec = 1'b1;
    while (q.size() < fit) begin
      room = fit - q.size();
      if (room < 6) begin
        repeat (room)
          q.push_back(($urandom_range(0, 2) == 0) ?
                      iptc_pkg::MARKER_BYTE : 8'($urandom_range(0, 255)));
        break;
      end
      q.push_back((!lead_rec && $urandom_range(0, 15) == 0) ?
                  8'($urandom_range(0, 255)) : iptc_pkg::MARKER_BYTE);
      q.push_back(lead_rec ? 8'($urandom_range(1, 2)) : 8'($urandom_range(0, 255)));
      q.push_back(8'($urandom_range(0, 255)));
      lead_rec = 1'b0;
      wide = room >= 10 && $urandom_range(0, 3) == 0;
      hdr = wide ? 9 : 5;
      room = room - hdr;
      case ($urandom_range(0, 15))
        0:       len = room + 1 + $urandom_range(0, 3);
        1, 2:    len = 0;
        default: len = $urandom_range(0, (room < 12) ? room : 12);
      endcase
      if (wide) begin
        if ($urandom_range(0, 7) == 0) len = $urandom;
        q.push_back(8'(8'h80 | $urandom_range(0, 127)));
        q.push_back(8'($urandom_range(0, 255)));
        q.push_back(len[31:24]);
        q.push_back(len[23:16]);
        q.push_back(len[15:8]);
        q.push_back(len[7:0]);
      end else begin
        q.push_back({1'b0, len[14:8]});
        q.push_back(len[7:0]);
      end
      n = (len > room) ? room : len;
      repeat (n) q.push_back(8'($urandom_range(0, 255)));
    end
    repeat (extra) q.push_back(8'($urandom_range(0, 255)));
  endfunction

  initial begin : stimulus
    int lens[$];
    int phase_end;
    int fit;
    int extra;
    logic [7:0] blk[$];
    logic [15:0] cur;
    book = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset length of one: the first byte ends the block, later bytes are ignored
    send_byte(8'h00, 1'b1);
    send_byte(iptc_pkg::MARKER_BYTE, 1'b0);
    // repeated marker, zero-length short record, long record, short header at the end
    write_length(16'd19);
    blk = '{8'h00, iptc_pkg::MARKER_BYTE, iptc_pkg::MARKER_BYTE, iptc_pkg::REC_TWO,
            8'h05, 8'h00, 8'h00,
            iptc_pkg::MARKER_BYTE, iptc_pkg::REC_ONE, 8'h07, 8'h80, 8'hff,
            8'h00, 8'h00, 8'h00, 8'h01,
            8'hbb, iptc_pkg::MARKER_BYTE, iptc_pkg::MARKER_BYTE};
    send_block(blk, 1'b0);
    // overlong length
    write_length(16'd6);
    blk = '{iptc_pkg::MARKER_BYTE, iptc_pkg::REC_ONE, 8'h03, 8'h00, 8'h09, 8'h44};
    send_block(blk, 1'b0);

    lens = '{0, 1, 2, 5, 6, 9, 10, 65535, 40, 24, 17, 11, 33, 65535};
    lens.push_back($urandom_range(11, 64));
    lens.push_back($urandom_range(11, 64));
    foreach (lens[k]) begin
      cur = 16'(lens[k]);
      write_length(cur);
      in_gap_max = (k % 2 == 1) ? 16 : 0;
      out_gap_max = (k % 4 >= 2) ? 16 : 0;
      if (cur == 16'd40) begin
        in_gap_max = 0;
        out_gap_max = 0;
        hold_req = 1'b1;
      end
      phase_end = live_items + PHASE_ITEMS;
      while (live_items < phase_end) begin
        fit = (cur > 100) ? $urandom_range(12, 60) : ((cur == 0) ? 1 : cur);
        extra = 0;
        case ($urandom_range(0, 7))
          0: fit = $urandom_range(1, fit);
          1: extra = $urandom_range(1, 3);
          default: ;
        endcase
        build_block(fit, extra, blk);
        send_block(blk, $urandom_range(0, 9) == 0);
      end
    end

    idle_input();
    while (book.awaited_items.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (book.awaited_items.size() != 0)
      book.flag($sformatf("%0d results never arrived", book.awaited_items.size()));
    if (book.fails == 0)
      $display("iptc_record_stream_parser_tb: done, clean");
    else
      $display("iptc_record_stream_parser_tb: done, errors");
    $finish;
  end

  initial begin : receiver
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = $urandom_range(0, out_gap_max);
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      book.match_item(out_data);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("iptc_record_stream_parser_tb: done, errors");
    $finish;
  end

endmodule
